// File: sv/ppu_sar_pkg.sv
package ppu_sar_pkg;

  // Event codes carried by the action field.
  typedef enum logic [3:0] {
    ACT_CTRL_WRITE   = 4'd0,
    ACT_STATUS_READ  = 4'd1,
    ACT_SCROLL_WRITE = 4'd2,
    ACT_ADDR_WRITE   = 4'd3,
    ACT_DATA_ACCESS  = 4'd4,
    ACT_INC_X        = 4'd5,
    ACT_INC_Y        = 4'd6,
    ACT_COPY_H       = 4'd7,
    ACT_COPY_V       = 4'd8,
    ACT_VBLANK       = 4'd9
  } action_e;

  localparam int unsigned AddrW = 15;

  // Positions at which the coarse and fine scroll counters wrap.
  localparam logic [4:0] CoarseYLast = 5'd29;
  localparam logic [4:0] CoarseMax   = 5'd31;
  localparam logic [2:0] FineYMax    = 3'd7;

  // Data port steps, chosen by control bit 2.
  localparam logic [AddrW-1:0] IncAcross = 15'd1;
  localparam logic [AddrW-1:0] IncDown   = 15'd32;

  // Architectural register file of the scroll logic.
  typedef struct packed {
    logic [AddrW-1:0] cur;
    logic [AddrW-1:0] tmp;
    logic [2:0]       fine_x;
    logic             toggle;
    logic [7:0]       ctrl;
    logic             vblank;
  } regs_t;

  // One event as held in the input stage.
  typedef struct packed {
    logic [3:0] action;
    logic [7:0] data;
    logic       render;
    logic       clr;
  } event_t;

  // One result as held in the output stage.
  typedef struct packed {
    logic [13:0] vram_address;
    logic [2:0]  fine_x;
    logic [13:0] tile_fetch_address;
    logic [13:0] attribute_fetch_address;
    logic [2:0]  attribute_shift;
    logic        status_vblank;
    logic        nmi_request;
  } result_t;

endpackage

// File: sv/ppu_sar_step.sv
module ppu_sar_step import ppu_sar_pkg::*; (
  input  regs_t   regs_i,
  input  event_t  ev_i,
  output regs_t   regs_o,
  output result_t res_o
);

  regs_t           nxt;
  logic            nmi;
  logic            seen;
  logic [4:0]      cy;
  logic [AddrW-1:0] v;

  // Apply one event to the register file.
  always_comb begin
    nxt = regs_i;
    nmi = 1'b0;
    cy  = regs_i.cur[9:5];
    unique case (action_e'(ev_i.action))
      ACT_CTRL_WRITE: begin
        nxt.ctrl       = ev_i.data;
        nxt.tmp[11:10] = ev_i.data[1:0];
      end
      ACT_STATUS_READ: begin
        nxt = regs_i;
      end
      ACT_SCROLL_WRITE: begin
        if (!regs_i.toggle) begin
          nxt.fine_x   = ev_i.data[2:0];
          nxt.tmp[4:0] = ev_i.data[7:3];
          nxt.toggle   = 1'b1;
        end else begin
          nxt.tmp[14:12] = ev_i.data[2:0];
          nxt.tmp[9:5]   = ev_i.data[7:3];
          nxt.toggle     = 1'b0;
        end
      end
      ACT_ADDR_WRITE: begin
        if (!regs_i.toggle) begin
          nxt.tmp[14]   = 1'b0;
          nxt.tmp[13:8] = ev_i.data[5:0];
          nxt.toggle    = 1'b1;
        end else begin
          nxt.tmp[7:0] = ev_i.data;
          nxt.cur      = {regs_i.tmp[14:8], ev_i.data};
          nxt.toggle   = 1'b0;
        end
      end
      ACT_DATA_ACCESS: begin
        nxt.cur = regs_i.cur + (regs_i.ctrl[2] ? IncDown : IncAcross);
      end
      ACT_INC_X: begin
        if (ev_i.render) begin
          if (regs_i.cur[4:0] == CoarseMax) begin
            nxt.cur[4:0] = 5'd0;
            nxt.cur[10]  = ~regs_i.cur[10];
          end else begin
            nxt.cur[4:0] = regs_i.cur[4:0] + 5'd1;
          end
        end
      end
      ACT_INC_Y: begin
        if (ev_i.render) begin
          if (regs_i.cur[14:12] != FineYMax) begin
            nxt.cur[14:12] = regs_i.cur[14:12] + 3'd1;
          end else begin
            nxt.cur[14:12] = 3'd0;
            if (regs_i.cur[9:5] == CoarseYLast) begin
              cy          = 5'd0;
              nxt.cur[11] = ~regs_i.cur[11];
            end else if (regs_i.cur[9:5] == CoarseMax) begin
              cy = 5'd0;
            end else begin
              cy = regs_i.cur[9:5] + 5'd1;
            end
            nxt.cur[9:5] = cy;
          end
        end
      end
      ACT_COPY_H: begin
        if (ev_i.render) begin
          nxt.cur[10]  = regs_i.tmp[10];
          nxt.cur[4:0] = regs_i.tmp[4:0];
        end
      end
      ACT_COPY_V: begin
        if (ev_i.render) begin
          nxt.cur[14:11] = regs_i.tmp[14:11];
          nxt.cur[9:5]   = regs_i.tmp[9:5];
        end
      end
      ACT_VBLANK: begin
        if (ev_i.clr) begin
          nxt.vblank = 1'b0;
        end else begin
          nxt.vblank = 1'b1;
          nmi        = regs_i.ctrl[7];
        end
      end
      default: begin
        nxt = regs_i;
      end
    endcase

    // A status read reports the flag and then clears it with the toggle.
    seen = nxt.vblank;
    if (action_e'(ev_i.action) == ACT_STATUS_READ) begin
      nxt.toggle = 1'b0;
      nxt.vblank = 1'b0;
    end
  end

  assign regs_o = nxt;
  assign v      = nxt.cur;

  // Fetch addresses implied by the new current address.
  always_comb begin
    res_o.vram_address            = v[13:0];
    res_o.fine_x                  = nxt.fine_x;
    res_o.tile_fetch_address      = {2'b10, v[11:0]};
    res_o.attribute_fetch_address = {2'b10, v[11:10], 4'b1111, v[9:7], v[4:2]};
    res_o.attribute_shift         = {v[6], v[1], 1'b0};
    res_o.status_vblank           = seen;
    res_o.nmi_request             = nmi;
  end

endmodule

// File: sv/ppu_scroll_address_registers_core.sv
// Scroll and address registers of a tile video processor.
// Requests enter on the in channel (valid/ready): one event per request,
// coded in action_i with its data byte and the rendering and clear flags.
// Each request yields exactly one result on the out channel (valid/ready):
// the current video address, fine X, the tile and attribute fetch addresses,
// the attribute shift, the vblank bit as a status read sees it and an NMI
// request.
// The block is two registers deep: a request is captured in the input
// stage, applied to the register file in one pass of logic and the result
// is registered in the output stage, from which it is offered. One request is
// taken per cycle for as long as the receiver keeps up; the next request
// depends on the state the previous one leaves, which is updated in the
// same cycle the result is registered.
// When the receiver stalls, the result holds and the input stage fills;
// in_ready_o falls only once both stages hold a request.
// Reset clears the addresses, fine X, the write toggle, the control byte,
// the vblank flag and both stage valid bits.
module ppu_scroll_address_registers_core import ppu_sar_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [3:0]  action_i,
  input  logic [7:0]  data_i,
  input  logic        rendering_enabled_i,
  input  logic        clear_vblank_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [13:0] vram_address_o,
  output logic [2:0]  fine_x_o,
  output logic [13:0] tile_fetch_address_o,
  output logic [13:0] attribute_fetch_address_o,
  output logic [2:0]  attribute_shift_o,
  output logic        status_vblank_o,
  output logic        nmi_request_o
);

  regs_t   regs_q, regs_d;
  event_t  ev_q;
  result_t res_q, res_d;
  logic    in_valid_q;
  logic    out_valid_q;
  logic    advance;

  // The input stage moves on when the output stage is free or being emptied.
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  ppu_sar_step u_step (
    .regs_i (regs_q),
    .ev_i   (ev_q),
    .regs_o (regs_d),
    .res_o  (res_d)
  );

  // Control state and the register file.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      regs_q      <= '0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        regs_q      <= regs_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload of the input stage.
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      ev_q <= '{action: action_i, data: data_i, render: rendering_enabled_i,
                clr: clear_vblank_i};
    end
  end

  // Payload of the output stage.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o               = out_valid_q;
  assign vram_address_o            = res_q.vram_address;
  assign fine_x_o                  = res_q.fine_x;
  assign tile_fetch_address_o      = res_q.tile_fetch_address;
  assign attribute_fetch_address_o = res_q.attribute_fetch_address;
  assign attribute_shift_o         = res_q.attribute_shift;
  assign status_vblank_o           = res_q.status_vblank;
  assign nmi_request_o             = res_q.nmi_request;

endmodule

// File: sv/ppu_sar_checker.sv
module ppu_sar_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [3:0]  action_i,
  input logic [7:0]  data_i,
  input logic        rendering_enabled_i,
  input logic        clear_vblank_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [13:0] vram_address_o,
  input logic [2:0]  fine_x_o,
  input logic [13:0] tile_fetch_address_o,
  input logic [13:0] attribute_fetch_address_o,
  input logic [2:0]  attribute_shift_o,
  input logic        status_vblank_o,
  input logic        nmi_request_o
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result withdrawn while stalled");

  // Tile fetch follows the low twelve bits of the current address.
  a_tile_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> tile_fetch_address_o[11:0] == vram_address_o[11:0]
                    && tile_fetch_address_o[13:12] == 2'b10)
    else $error("tile fetch address does not follow current address");

  // Attribute fetch keeps the nametable bits and the shift the coarse bits.
  a_attr_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> attribute_fetch_address_o[11:10] == vram_address_o[11:10]
                    && attribute_shift_o[2] == vram_address_o[6]
                    && attribute_shift_o[1] == vram_address_o[1]
                    && attribute_shift_o[0] == 1'b0)
    else $error("attribute fetch does not follow current address");

  // An NMI request only accompanies a set vblank flag.
  a_nmi_vblank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && nmi_request_o |-> status_vblank_o)
    else $error("NMI request without vblank");

endmodule

bind ppu_scroll_address_registers_core ppu_sar_checker u_ppu_sar_checker (.*);
